[hw/rtl/tfa_pkg.sv]
package tfa_pkg;

    // Buffer geometry
    localparam int FRAME_DEPTH      = 64;
    localparam int TERMINATOR_SLOTS = 4;
    localparam int TERM_REGS        = 4;
    localparam int ADDR_W           = $clog2(FRAME_DEPTH);
    localparam int FILL_W           = $clog2(FRAME_DEPTH + 1);

    // Field and register widths
    localparam int BYTE_W    = 8;
    localparam int ACTIVE_W  = 3;
    localparam int TIMEOUT_W = 16;
    localparam int LIMIT_W   = 7;
    localparam int SILENCE_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [FILL_W-1:0]    fill_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Item kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Register indexes
    localparam cfg_idx_t REG_ACTIVE_TERM  = 3'd0;
    localparam cfg_idx_t REG_TERM_A       = 3'd1;
    localparam cfg_idx_t REG_TERM_B       = 3'd2;
    localparam cfg_idx_t REG_TERM_C       = 3'd3;
    localparam cfg_idx_t REG_TERM_D       = 3'd4;
    localparam cfg_idx_t REG_IDLE_TIMEOUT = 3'd5;
    localparam cfg_idx_t REG_OUTPUT_LIMIT = 3'd6;

    // Frame buffer port bundle
    typedef struct packed {
        logic  we;
        addr_t waddr;
        byte_t wdata;
        logic  re;
        addr_t raddr;
    } buf_req_t;

endpackage

[hw/rtl/tfa_if.sv]
interface tfa_item_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [8-1:0]         data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface tfa_result_if;
    logic                 valid;
    logic                 ready;
    logic [8-1:0]         frame_byte;
    logic                 last_of_frame;
    logic                 closed_by_timeout;

    modport source (output valid, output frame_byte, output last_of_frame,
                    output closed_by_timeout, input ready);
    modport sink (input valid, input frame_byte, input last_of_frame,
                  input closed_by_timeout, output ready);
endinterface

[hw/rtl/tfa_frame_buf.sv]
module tfa_frame_buf
(
    input  logic              clk,
    input  tfa_pkg::buf_req_t req,
    output tfa_pkg::byte_t    rdata
);

    tfa_pkg::byte_t mem [tfa_pkg::FRAME_DEPTH];
    tfa_pkg::byte_t rdata_reg;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/terminated_frame_assembler_unit.sv]
// Frame assembler for a delimited byte stream. Each item is either a received
// byte or a one millisecond tick. Bytes are buffered in a 64-entry frame RAM;
// a byte equal to one of the active terminator registers closes a non-empty
// frame unless the buffer is full, and a tick that finds the silence since
// the last byte above a non-zero idle timeout closes a non-empty frame as
// well (flagged closed_by_timeout). The buffered bytes, cut to output_limit,
// come out one beat each with last_of_frame on the final one. While
// collecting, an item is accepted every cycle. Closing a frame holds the
// input off while its emitted bytes are read out through the single read
// port of the frame RAM, one byte a cycle unless the result side stalls. A
// closing item with an empty buffer or a zero output limit emits nothing and
// holds off nothing. The frame RAM needs no clearing after reset.
module terminated_frame_assembler_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    tfa_item_if.sink                     item,
    tfa_result_if.source                 result,
    input  logic                         cfg_we,
    input  tfa_pkg::cfg_idx_t            cfg_index,
    input  logic [tfa_pkg::CFG_DAT_W-1:0] cfg_data
);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    // Configuration registers
    logic [tfa_pkg::ACTIVE_W-1:0]  active_reg;
    tfa_pkg::byte_t                term_reg [tfa_pkg::TERM_REGS];
    logic [tfa_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [tfa_pkg::LIMIT_W-1:0]   limit_reg;

    // Control and output state
    state_t                        state_reg, state_next;
    tfa_pkg::fill_t                fill_reg, fill_next;
    logic [tfa_pkg::SILENCE_W-1:0] silence_reg, silence_next;
    tfa_pkg::fill_t                rem_reg, rem_next;
    tfa_pkg::addr_t                rd_idx_reg, rd_idx_next;
    logic                          rd_pend_reg, rd_pend_next;
    logic                          pend_last_reg, pend_last_next;
    logic                          tmo_flag_reg, tmo_flag_next;
    logic                          out_valid_reg, out_valid_next;
    tfa_pkg::byte_t                out_byte_reg, out_byte_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_tmo_reg, out_tmo_next;

    tfa_pkg::buf_req_t             buf_req;
    tfa_pkg::byte_t                buf_rdata;

    logic                          accept;
    logic                          load_now;
    logic                          term_match;
    logic [tfa_pkg::ACTIVE_W-1:0]  n_active;
    logic [tfa_pkg::SILENCE_W-1:0] silence_inc;
    tfa_pkg::fill_t                emit_cnt;

    tfa_frame_buf u_buf
    (
        .clk   (clk),
        .req   (buf_req),
        .rdata (buf_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 3'd2;
            term_reg[0] <= 8'd13;
            term_reg[1] <= 8'd10;
            term_reg[2] <= 8'd0;
            term_reg[3] <= 8'd0;
            timeout_reg <= 16'd50;
            limit_reg   <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tfa_pkg::REG_ACTIVE_TERM:  active_reg  <= cfg_data[tfa_pkg::ACTIVE_W-1:0];
                tfa_pkg::REG_TERM_A:       term_reg[0] <= cfg_data[tfa_pkg::BYTE_W-1:0];
                tfa_pkg::REG_TERM_B:       term_reg[1] <= cfg_data[tfa_pkg::BYTE_W-1:0];
                tfa_pkg::REG_TERM_C:       term_reg[2] <= cfg_data[tfa_pkg::BYTE_W-1:0];
                tfa_pkg::REG_TERM_D:       term_reg[3] <= cfg_data[tfa_pkg::BYTE_W-1:0];
                tfa_pkg::REG_IDLE_TIMEOUT: timeout_reg <= cfg_data[tfa_pkg::TIMEOUT_W-1:0];
                tfa_pkg::REG_OUTPUT_LIMIT: limit_reg   <= cfg_data[tfa_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Terminator compare over the active slots
    always_comb
    begin
        n_active = (active_reg > tfa_pkg::ACTIVE_W'(tfa_pkg::TERMINATOR_SLOTS))
                 ? tfa_pkg::ACTIVE_W'(tfa_pkg::TERMINATOR_SLOTS) : active_reg;
        term_match = 1'b0;
        for (int i = 0; i < tfa_pkg::TERMINATOR_SLOTS; i++)
        begin
            if ((tfa_pkg::ACTIVE_W'(i) < n_active) && (term_reg[i] == item.data_byte))
            begin
                term_match = 1'b1;
            end
        end
    end

    // Saturating silence count and clipped frame length
    assign silence_inc = (&silence_reg) ? silence_reg
                       : silence_reg + tfa_pkg::SILENCE_W'(1);
    assign emit_cnt = (tfa_pkg::LIMIT_W'(fill_reg) > limit_reg)
                    ? tfa_pkg::FILL_W'(limit_reg) : fill_reg;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    // Pending RAM data moves into the output register when that is free
    assign load_now   = rd_pend_reg && (!out_valid_reg || result.ready);

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        silence_next   = silence_reg;
        rem_next       = rem_reg;
        rd_idx_next    = rd_idx_reg;
        pend_last_next = pend_last_reg;
        tmo_flag_next  = tmo_flag_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_tmo_next   = out_tmo_reg;
        rd_pend_next   = load_now ? 1'b0 : rd_pend_reg;

        buf_req.we    = 1'b0;
        buf_req.waddr = fill_reg[tfa_pkg::ADDR_W-1:0];
        buf_req.wdata = item.data_byte;
        buf_req.re    = 1'b0;
        buf_req.raddr = rd_idx_reg;

        // Output register
        if (load_now)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = buf_rdata;
            out_last_next  = pend_last_reg;
            out_tmo_next   = tmo_flag_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode == tfa_pkg::MODE_BYTE)
                    begin
                        silence_next = '0;
                        if (fill_reg < tfa_pkg::FILL_W'(tfa_pkg::FRAME_DEPTH))
                        begin
                            if (term_match)
                            begin
                                if (fill_reg != '0)
                                begin
                                    fill_next     = '0;
                                    tmo_flag_next = 1'b0;
                                    rd_idx_next   = '0;
                                    rem_next      = emit_cnt;
                                    if (emit_cnt != '0)
                                    begin
                                        state_next = ST_EMIT;
                                    end
                                end
                            end
                            else
                            begin
                                buf_req.we = 1'b1;
                                fill_next  = fill_reg + tfa_pkg::FILL_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        silence_next = silence_inc;
                        if ((fill_reg != '0) && (timeout_reg != '0)
                            && (silence_inc > tfa_pkg::SILENCE_W'(timeout_reg)))
                        begin
                            fill_next     = '0;
                            tmo_flag_next = 1'b1;
                            rd_idx_next   = '0;
                            rem_next      = emit_cnt;
                            if (emit_cnt != '0)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (!rd_pend_reg || load_now)
                begin
                    if (rem_reg != '0)
                    begin
                        // Read one byte a cycle unless the output register is stalled
                        buf_req.re     = 1'b1;
                        rd_idx_next    = rd_idx_reg + tfa_pkg::ADDR_W'(1);
                        rem_next       = rem_reg - tfa_pkg::FILL_W'(1);
                        rd_pend_next   = 1'b1;
                        pend_last_next = (rem_reg == tfa_pkg::FILL_W'(1));
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            silence_reg   <= '0;
            rem_reg       <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            pend_last_reg <= 1'b0;
            tmo_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_tmo_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            silence_reg   <= silence_next;
            rem_reg       <= rem_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            pend_last_reg <= pend_last_next;
            tmo_flag_reg  <= tmo_flag_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_tmo_reg   <= out_tmo_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.frame_byte        = out_byte_reg;
    assign result.last_of_frame     = out_last_reg;
    assign result.closed_by_timeout = out_tmo_reg;

    // A RAM read is only outstanding while a frame is being read out
    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_EMIT))
        else $error("read outstanding outside readout");

    // Nothing is buffered while a frame is being read out
    a_empty_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (fill_reg == '0))
        else $error("buffer not empty during readout");

    // Input is taken only with no bytes left to read
    a_ready_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> (rem_reg == '0))
        else $error("input ready with bytes left");

    // Fill never exceeds the buffer
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= tfa_pkg::FILL_W'(tfa_pkg::FRAME_DEPTH))
        else $error("fill count overflow");

    // A finished readout returns to collecting
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (rem_reg == '0) && !rd_pend_reg)
        |=> (state_reg == ST_IDLE))
        else $error("readout did not finish");

endmodule
